// ----- rtl/core/mission_transfer_sequencer_core_macros.svh -----
// Assertion macros shared by the mission transfer sequencer RTL.
`ifndef MISSION_TRANSFER_SEQUENCER_CORE_MACROS_SVH
`define MISSION_TRANSFER_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MTS_ASSERT_IMPL(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MTS_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/core/mts_pkg.sv -----
// Types, codes and constants of the mission transfer sequencer.
package mts_pkg;

  localparam int SEQ_BITS = 16;
  localparam int CS_BITS = 16;
  localparam int unsigned SEQ_MAX = (1 << SEQ_BITS) - 1;
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);
  localparam int CFG_IDX_BITS = 2;

  typedef logic [SEQ_BITS-1:0] seq_t;

  localparam logic [CFG_IDX_BITS-1:0] CFG_LOCAL_SYS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOCAL_COMP = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_RETRIES = 2'd2;

  localparam logic [3:0] RES_ACCEPTED = 4'd0;
  localparam logic [3:0] RES_ERROR = 4'd1;
  localparam logic [3:0] RES_UNSUPPORTED = 4'd3;
  localparam logic [3:0] RES_NO_SPACE = 4'd4;
  localparam logic [3:0] RES_INVALID_SEQUENCE = 4'd13;
  localparam logic [3:0] RES_OPERATION_CANCELLED = 4'd15;
  localparam logic [7:0] RES_ENUM_END = 8'd16;
  localparam logic [7:0] MAX_KNOWN_KIND = 8'd2;
  localparam logic [7:0] MAX_RETRIES_RESET = 8'd3;

  typedef enum logic [2:0] {
    EV_START_DOWN = 3'd0,
    EV_START_UP   = 3'd1,
    EV_COUNT      = 3'd2,
    EV_ITEM       = 3'd3,
    EV_REQUEST    = 3'd4,
    EV_ACK        = 3'd5,
    EV_TIMEOUT    = 3'd6,
    EV_CANCEL     = 3'd7
  } event_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_WCOUNT = 3'd1,
    PH_WITEM  = 3'd2,
    PH_WREQ   = 3'd3,
    PH_WACK   = 3'd4,
    PH_DONE   = 3'd5,
    PH_CANCEL = 3'd6,
    PH_ERROR  = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_DOWN = 2'd1,
    DIR_UP   = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    MK_REQLIST = 3'd0,
    MK_COUNT   = 3'd1,
    MK_REQ     = 3'd2,
    MK_REQINT  = 3'd3,
    MK_ITEM    = 3'd4,
    MK_ITEMINT = 3'd5,
    MK_ACK     = 3'd6
  } msg_kind_t;

  // One classified event as it waits in the queue.
  typedef struct packed {
    event_t             evt;
    logic [7:0]         peer_system;
    logic [7:0]         peer_component;
    logic [7:0]         mission_kind;
    logic [7:0]         dest_system;
    logic [7:0]         dest_component;
    logic [CS_BITS-1:0] count_or_seq;
    logic               int_variant;
    logic [7:0]         ack_code;
    logic               unsupported;
    logic               oversize;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic               handled;
    logic               send_valid;
    msg_kind_t          msg_kind;
    logic [CS_BITS-1:0] msg_seq;
    logic [3:0]         msg_ack;
    logic               resend;
    logic               store_item;
    phase_t             phase;
    logic [3:0]         outcome;
    logic [7:0]         msg_dest_system;
    logic [7:0]         msg_dest_component;
    logic [7:0]         msg_mission_kind;
  } result_t;

endpackage

// ----- rtl/core/mts_if.sv -----
// Input and result channel interfaces of the mission transfer sequencer.
interface mts_in_if;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 req_type;
  logic [7:0]                 peer_system;
  logic [7:0]                 peer_component;
  logic [7:0]                 mission_kind;
  logic [7:0]                 dest_system_in;
  logic [7:0]                 dest_component_in;
  logic [mts_pkg::CS_BITS-1:0] count_or_seq;
  logic                       int_variant;
  logic [7:0]                 ack_code;

  modport source (
    output valid, req_type, peer_system, peer_component, mission_kind,
           dest_system_in, dest_component_in, count_or_seq, int_variant, ack_code,
    input  ready
  );
  modport sink (
    input  valid, req_type, peer_system, peer_component, mission_kind,
           dest_system_in, dest_component_in, count_or_seq, int_variant, ack_code,
    output ready
  );
endinterface

interface mts_out_if;
  logic                       valid;
  logic                       ready;
  logic                       handled;
  logic                       send_valid;
  logic [2:0]                 msg_kind;
  logic [mts_pkg::CS_BITS-1:0] msg_seq;
  logic [3:0]                 msg_ack;
  logic                       resend;
  logic                       store_item;
  logic [2:0]                 phase;
  logic [3:0]                 outcome;
  logic [7:0]                 msg_dest_system;
  logic [7:0]                 msg_dest_component;
  logic [7:0]                 msg_mission_kind;

  modport source (
    output valid, handled, send_valid, msg_kind, msg_seq, msg_ack, resend, store_item,
           phase, outcome, msg_dest_system, msg_dest_component, msg_mission_kind,
    input  ready
  );
  modport sink (
    input  valid, handled, send_valid, msg_kind, msg_seq, msg_ack, resend, store_item,
           phase, outcome, msg_dest_system, msg_dest_component, msg_mission_kind,
    output ready
  );
endinterface

// ----- rtl/core/mts_front.sv -----
// Front end: accepts event transactions and classifies them for the queue.
module mts_front (
  mts_in_if.sink          in_chan,
  input  logic            fifo_full,
  output logic            push,
  output mts_pkg::item_t  push_item
);

  mts_pkg::event_t evt;

  always_comb begin
    case (in_chan.req_type)
      mts_pkg::EV_START_DOWN: evt = mts_pkg::EV_START_DOWN;
      mts_pkg::EV_START_UP:   evt = mts_pkg::EV_START_UP;
      mts_pkg::EV_COUNT:      evt = mts_pkg::EV_COUNT;
      mts_pkg::EV_ITEM:       evt = mts_pkg::EV_ITEM;
      mts_pkg::EV_REQUEST:    evt = mts_pkg::EV_REQUEST;
      mts_pkg::EV_ACK:        evt = mts_pkg::EV_ACK;
      mts_pkg::EV_TIMEOUT:    evt = mts_pkg::EV_TIMEOUT;
      default:                evt = mts_pkg::EV_CANCEL;
    endcase
  end

  assign in_chan.ready = !fifo_full;
  assign push = in_chan.valid && !fifo_full;

  always_comb begin
    push_item.evt            = evt;
    push_item.peer_system    = in_chan.peer_system;
    push_item.peer_component = in_chan.peer_component;
    push_item.mission_kind   = in_chan.mission_kind;
    push_item.dest_system    = in_chan.dest_system_in;
    push_item.dest_component = in_chan.dest_component_in;
    push_item.count_or_seq   = in_chan.count_or_seq;
    push_item.int_variant    = in_chan.int_variant;
    push_item.ack_code       = in_chan.ack_code;
    push_item.unsupported    = in_chan.mission_kind > mts_pkg::MAX_KNOWN_KIND;
    push_item.oversize       = 32'(in_chan.count_or_seq) > mts_pkg::SEQ_MAX;
  end

endmodule

// ----- rtl/core/mts_fifo.sv -----
// Short queue of classified events between the front and back ends.
`include "mission_transfer_sequencer_core_macros.svh"

module mts_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  mts_pkg::item_t       wr_data,
  output logic                 full,
  input  logic                 rd_en,
  output logic                 rd_valid,
  output mts_pkg::item_t       rd_data
);

  mts_pkg::item_t                  slot_r [mts_pkg::FIFO_DEPTH];
  logic [mts_pkg::PTR_BITS-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [mts_pkg::PTR_BITS-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [mts_pkg::CNT_BITS-1:0]    count_r, count_nxt;

  assign full     = count_r == mts_pkg::CNT_BITS'(mts_pkg::FIFO_DEPTH);
  assign rd_valid = count_r != '0;
  assign rd_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == mts_pkg::FIFO_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == mts_pkg::FIFO_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  `MTS_ASSERT_IMPL(a_no_write_when_full, clk, rst_n, full, !wr_en, "queue written while full")
  `MTS_ASSERT_IMPL(a_no_read_when_empty, clk, rst_n, !rd_valid, !rd_en, "queue read while empty")
  `MTS_ASSERT_NEXT(a_write_fills, clk, rst_n, wr_en && !rd_en, count_r != '0, "write lost")

endmodule

// ----- rtl/core/mts_back.sv -----
// Back end: transfer state machine, configuration registers and result register.
`include "mission_transfer_sequencer_core_macros.svh"

module mts_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              item_valid,
  input  mts_pkg::item_t                    item,
  output logic                              pop,
  input  logic                              cfg_we,
  input  logic [mts_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [7:0]                        cfg_data,
  mts_out_if.source                         out_chan
);

  mts_pkg::phase_t    phase_r, phase_nxt;
  mts_pkg::dir_t      dir_r, dir_nxt;
  logic [7:0]         key_sys_r, key_sys_nxt;
  logic [7:0]         key_comp_r, key_comp_nxt;
  logic [7:0]         key_kind_r, key_kind_nxt;
  mts_pkg::seq_t      total_r, total_nxt;
  mts_pkg::seq_t      next_r, next_nxt;
  logic [7:0]         retries_r, retries_nxt;
  logic               last_valid_r, last_valid_nxt;
  mts_pkg::msg_kind_t last_kind_r, last_kind_nxt;
  mts_pkg::seq_t      last_seq_r, last_seq_nxt;
  logic [3:0]         outcome_r, outcome_nxt;
  logic [7:0]         loc_sys_r, loc_sys_nxt;
  logic [7:0]         loc_comp_r, loc_comp_nxt;
  logic [7:0]         max_retries_r, max_retries_nxt;
  logic               out_valid_r, out_valid_nxt;
  mts_pkg::result_t   out_r, res;

  logic                                active;
  logic                                hdr_match;
  logic [3:0]                          ack_res;
  logic [mts_pkg::CS_BITS-1:0]         cs;
  logic [mts_pkg::CS_BITS-1:0]         next_w;
  logic [mts_pkg::CS_BITS-1:0]         prev_w;
  mts_pkg::seq_t                       next_inc;
  mts_pkg::msg_kind_t                  req_kind;
  mts_pkg::msg_kind_t                  item_kind;

  assign active = phase_r inside {mts_pkg::PH_WCOUNT, mts_pkg::PH_WITEM,
                                  mts_pkg::PH_WREQ, mts_pkg::PH_WACK};
  assign hdr_match = item.peer_system == key_sys_r && item.peer_component == key_comp_r
                  && item.mission_kind == key_kind_r && item.dest_system == loc_sys_r
                  && item.dest_component == loc_comp_r;
  assign ack_res = (item.ack_code < mts_pkg::RES_ENUM_END) ? item.ack_code[3:0]
                                                           : mts_pkg::RES_ERROR;
  assign cs        = item.count_or_seq;
  assign next_inc  = next_r + 1'b1;
  assign next_w    = mts_pkg::CS_BITS'(next_r);
  assign prev_w    = mts_pkg::CS_BITS'(mts_pkg::seq_t'(next_r - 1'b1));
  assign req_kind  = item.int_variant ? mts_pkg::MK_REQINT : mts_pkg::MK_REQ;
  assign item_kind = item.int_variant ? mts_pkg::MK_ITEMINT : mts_pkg::MK_ITEM;

  // The result register frees itself in the same cycle it is taken.
  assign pop = item_valid && (!out_valid_r || out_chan.ready);

  always_comb begin
    phase_nxt       = phase_r;
    dir_nxt         = dir_r;
    key_sys_nxt     = key_sys_r;
    key_comp_nxt    = key_comp_r;
    key_kind_nxt    = key_kind_r;
    total_nxt       = total_r;
    next_nxt        = next_r;
    retries_nxt     = retries_r;
    last_valid_nxt  = last_valid_r;
    last_kind_nxt   = last_kind_r;
    last_seq_nxt    = last_seq_r;
    outcome_nxt     = outcome_r;
    loc_sys_nxt     = loc_sys_r;
    loc_comp_nxt    = loc_comp_r;
    max_retries_nxt = max_retries_r;
    res             = '0;

    if (cfg_we) begin
      case (cfg_index)
        mts_pkg::CFG_LOCAL_SYS:   if (!active) loc_sys_nxt = cfg_data;
        mts_pkg::CFG_LOCAL_COMP:  if (!active) loc_comp_nxt = cfg_data;
        mts_pkg::CFG_MAX_RETRIES: max_retries_nxt = cfg_data;
        default: ;
      endcase
    end

    if (pop) begin
      case (item.evt)
        mts_pkg::EV_START_DOWN, mts_pkg::EV_START_UP: begin
          if (!active) begin
            phase_nxt      = mts_pkg::PH_IDLE;
            dir_nxt        = (item.evt == mts_pkg::EV_START_DOWN) ? mts_pkg::DIR_DOWN
                                                                  : mts_pkg::DIR_UP;
            key_sys_nxt    = item.peer_system;
            key_comp_nxt   = item.peer_component;
            key_kind_nxt   = item.mission_kind;
            total_nxt      = '0;
            next_nxt       = '0;
            retries_nxt    = '0;
            last_valid_nxt = 1'b0;
            last_kind_nxt  = mts_pkg::MK_REQLIST;
            last_seq_nxt   = '0;
            outcome_nxt    = mts_pkg::RES_ACCEPTED;
            res.handled    = 1'b1;
            if (item.unsupported) begin
              phase_nxt   = mts_pkg::PH_ERROR;
              outcome_nxt = mts_pkg::RES_UNSUPPORTED;
            end else if (item.evt == mts_pkg::EV_START_DOWN) begin
              phase_nxt      = mts_pkg::PH_WCOUNT;
              res.send_valid = 1'b1;
              res.msg_kind   = mts_pkg::MK_REQLIST;
              last_valid_nxt = 1'b1;
            end else if (item.oversize) begin
              phase_nxt   = mts_pkg::PH_ERROR;
              outcome_nxt = mts_pkg::RES_NO_SPACE;
            end else begin
              total_nxt      = mts_pkg::seq_t'(cs);
              phase_nxt      = (cs == '0) ? mts_pkg::PH_WACK : mts_pkg::PH_WREQ;
              res.send_valid = 1'b1;
              res.msg_kind   = mts_pkg::MK_COUNT;
              res.msg_seq    = cs;
              last_valid_nxt = 1'b1;
              last_kind_nxt  = mts_pkg::MK_COUNT;
              last_seq_nxt   = mts_pkg::seq_t'(cs);
            end
          end
        end
        mts_pkg::EV_COUNT: begin
          if (dir_r == mts_pkg::DIR_DOWN && phase_r == mts_pkg::PH_WCOUNT && hdr_match) begin
            res.handled    = 1'b1;
            res.send_valid = 1'b1;
            retries_nxt    = '0;
            if (item.oversize) begin
              phase_nxt      = mts_pkg::PH_ERROR;
              outcome_nxt    = mts_pkg::RES_NO_SPACE;
              last_valid_nxt = 1'b0;
              res.msg_kind   = mts_pkg::MK_ACK;
              res.msg_ack    = mts_pkg::RES_NO_SPACE;
            end else begin
              total_nxt = mts_pkg::seq_t'(cs);
              next_nxt  = '0;
              if (cs == '0) begin
                phase_nxt      = mts_pkg::PH_DONE;
                outcome_nxt    = mts_pkg::RES_ACCEPTED;
                last_valid_nxt = 1'b0;
                res.msg_kind   = mts_pkg::MK_ACK;
                res.msg_ack    = mts_pkg::RES_ACCEPTED;
              end else begin
                phase_nxt      = mts_pkg::PH_WITEM;
                res.msg_kind   = mts_pkg::MK_REQINT;
                last_valid_nxt = 1'b1;
                last_kind_nxt  = mts_pkg::MK_REQINT;
                last_seq_nxt   = '0;
              end
            end
          end
        end
        mts_pkg::EV_ITEM: begin
          if (dir_r == mts_pkg::DIR_DOWN && phase_r == mts_pkg::PH_WITEM && hdr_match) begin
            res.handled    = 1'b1;
            res.send_valid = 1'b1;
            retries_nxt    = '0;
            if (next_r != '0 && cs == prev_w) begin
              // Duplicate of the previous item: ask for the current one again.
              res.msg_kind   = req_kind;
              res.msg_seq    = next_w;
              last_valid_nxt = 1'b1;
              last_kind_nxt  = req_kind;
              last_seq_nxt   = next_r;
            end else if (cs != next_w) begin
              phase_nxt      = mts_pkg::PH_ERROR;
              outcome_nxt    = mts_pkg::RES_INVALID_SEQUENCE;
              last_valid_nxt = 1'b0;
              res.msg_kind   = mts_pkg::MK_ACK;
              res.msg_ack    = mts_pkg::RES_INVALID_SEQUENCE;
            end else begin
              res.store_item = 1'b1;
              next_nxt       = next_inc;
              if (next_inc < total_r) begin
                res.msg_kind   = req_kind;
                res.msg_seq    = mts_pkg::CS_BITS'(next_inc);
                last_valid_nxt = 1'b1;
                last_kind_nxt  = req_kind;
                last_seq_nxt   = next_inc;
              end else begin
                phase_nxt      = mts_pkg::PH_DONE;
                outcome_nxt    = mts_pkg::RES_ACCEPTED;
                last_valid_nxt = 1'b0;
                res.msg_kind   = mts_pkg::MK_ACK;
                res.msg_seq    = cs;
                res.msg_ack    = mts_pkg::RES_ACCEPTED;
              end
            end
          end
        end
        mts_pkg::EV_REQUEST: begin
          if (dir_r == mts_pkg::DIR_UP && hdr_match
              && (phase_r == mts_pkg::PH_WREQ || phase_r == mts_pkg::PH_WACK)) begin
            res.handled = 1'b1;
            retries_nxt = '0;
            if (cs >= mts_pkg::CS_BITS'(total_r)) begin
              phase_nxt      = mts_pkg::PH_ERROR;
              outcome_nxt    = mts_pkg::RES_INVALID_SEQUENCE;
              last_valid_nxt = 1'b0;
            end else if (cs == next_w || (next_r != '0 && cs == prev_w)) begin
              if (cs == next_w) begin
                next_nxt  = next_inc;
                phase_nxt = (next_inc == total_r) ? mts_pkg::PH_WACK : mts_pkg::PH_WREQ;
              end
              res.send_valid = 1'b1;
              res.msg_kind   = item_kind;
              res.msg_seq    = cs;
              last_valid_nxt = 1'b1;
              last_kind_nxt  = item_kind;
              last_seq_nxt   = mts_pkg::seq_t'(cs);
            end else begin
              phase_nxt      = mts_pkg::PH_ERROR;
              outcome_nxt    = mts_pkg::RES_INVALID_SEQUENCE;
              last_valid_nxt = 1'b0;
            end
          end
        end
        mts_pkg::EV_ACK: begin
          if (active && hdr_match
              && (dir_r == mts_pkg::DIR_DOWN || dir_r == mts_pkg::DIR_UP)) begin
            if (ack_res != mts_pkg::RES_ACCEPTED) begin
              res.handled    = 1'b1;
              phase_nxt      = mts_pkg::PH_ERROR;
              outcome_nxt    = ack_res;
              retries_nxt    = '0;
              last_valid_nxt = 1'b0;
            end else if (dir_r == mts_pkg::DIR_UP) begin
              res.handled    = 1'b1;
              retries_nxt    = '0;
              last_valid_nxt = 1'b0;
              if (next_r != total_r) begin
                phase_nxt   = mts_pkg::PH_ERROR;
                outcome_nxt = mts_pkg::RES_INVALID_SEQUENCE;
              end else begin
                phase_nxt   = mts_pkg::PH_DONE;
                outcome_nxt = mts_pkg::RES_ACCEPTED;
              end
            end
          end
        end
        mts_pkg::EV_TIMEOUT: begin
          if (active && last_valid_r) begin
            res.handled = 1'b1;
            if (retries_r >= max_retries_r) begin
              phase_nxt      = mts_pkg::PH_ERROR;
              outcome_nxt    = mts_pkg::RES_ERROR;
              retries_nxt    = '0;
              last_valid_nxt = 1'b0;
            end else begin
              retries_nxt    = retries_r + 1'b1;
              res.send_valid = 1'b1;
              res.msg_kind   = last_kind_r;
              res.msg_seq    = mts_pkg::CS_BITS'(last_seq_r);
              res.resend     = 1'b1;
            end
          end
        end
        default: begin
          if (active) begin
            phase_nxt      = mts_pkg::PH_CANCEL;
            outcome_nxt    = mts_pkg::RES_OPERATION_CANCELLED;
            retries_nxt    = '0;
            last_valid_nxt = 1'b0;
            res.handled    = 1'b1;
            res.send_valid = 1'b1;
            res.msg_kind   = mts_pkg::MK_ACK;
            res.msg_ack    = mts_pkg::RES_OPERATION_CANCELLED;
          end
        end
      endcase
    end

    res.phase              = phase_nxt;
    res.outcome            = outcome_nxt;
    res.msg_dest_system    = key_sys_nxt;
    res.msg_dest_component = key_comp_nxt;
    res.msg_mission_kind   = key_kind_nxt;

    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= mts_pkg::PH_IDLE;
      dir_r         <= mts_pkg::DIR_NONE;
      key_sys_r     <= '0;
      key_comp_r    <= '0;
      key_kind_r    <= '0;
      total_r       <= '0;
      next_r        <= '0;
      retries_r     <= '0;
      last_valid_r  <= 1'b0;
      last_kind_r   <= mts_pkg::MK_REQLIST;
      last_seq_r    <= '0;
      outcome_r     <= mts_pkg::RES_ACCEPTED;
      loc_sys_r     <= '0;
      loc_comp_r    <= '0;
      max_retries_r <= mts_pkg::MAX_RETRIES_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      dir_r         <= dir_nxt;
      key_sys_r     <= key_sys_nxt;
      key_comp_r    <= key_comp_nxt;
      key_kind_r    <= key_kind_nxt;
      total_r       <= total_nxt;
      next_r        <= next_nxt;
      retries_r     <= retries_nxt;
      last_valid_r  <= last_valid_nxt;
      last_kind_r   <= last_kind_nxt;
      last_seq_r    <= last_seq_nxt;
      outcome_r     <= outcome_nxt;
      loc_sys_r     <= loc_sys_nxt;
      loc_comp_r    <= loc_comp_nxt;
      max_retries_r <= max_retries_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= res;
    end
  end

  assign out_chan.valid              = out_valid_r;
  assign out_chan.handled            = out_r.handled;
  assign out_chan.send_valid         = out_r.send_valid;
  assign out_chan.msg_kind           = out_r.msg_kind;
  assign out_chan.msg_seq            = out_r.msg_seq;
  assign out_chan.msg_ack            = out_r.msg_ack;
  assign out_chan.resend             = out_r.resend;
  assign out_chan.store_item         = out_r.store_item;
  assign out_chan.phase              = out_r.phase;
  assign out_chan.outcome            = out_r.outcome;
  assign out_chan.msg_dest_system    = out_r.msg_dest_system;
  assign out_chan.msg_dest_component = out_r.msg_dest_component;
  assign out_chan.msg_mission_kind   = out_r.msg_mission_kind;

  `MTS_ASSERT_IMPL(a_idle_without_dir, clk, rst_n, dir_r == mts_pkg::DIR_NONE, phase_r == mts_pkg::PH_IDLE, "direction lost while a transfer is open")
  `MTS_ASSERT_IMPL(a_next_within_total, clk, rst_n, 1'b1, next_r <= total_r, "next sequence ran past the item count")
  `MTS_ASSERT_IMPL(a_retries_need_last, clk, rst_n, !last_valid_r, retries_r == '0, "retry count kept without a message to resend")
  `MTS_ASSERT_IMPL(a_bad_outcome_ends, clk, rst_n, outcome_r != mts_pkg::RES_ACCEPTED, phase_r == mts_pkg::PH_ERROR || phase_r == mts_pkg::PH_CANCEL, "failure code outside a failed phase")

endmodule

// ----- rtl/core/mission_transfer_sequencer_core.sv -----
// An accepted transaction goes into a queue slot, then is popped into the result register.
// Throughput: one event per cycle while results are taken, set by the single-step back end.
// A two-entry queue decouples input acceptance from result stalls; ready drops only when full.
// Reset: synchronous, active low; phase idle, no direction, key and counters zero, outcome
// accepted, local identity zero and max retries three. No clearing pass is needed.
module mission_transfer_sequencer_core (
  input  logic                              clk,
  input  logic                              rst_n,
  mts_in_if.sink                            in_chan,
  mts_out_if.source                         out_chan,
  input  logic                              cfg_we,
  input  logic [mts_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [7:0]                        cfg_data
);

  // The front end only decodes the event code and flags the fields that do not depend on
  // transfer state: an unsupported mission type and a count beyond the sequence range.
  logic           push;
  logic           fifo_full;
  logic           item_valid;
  logic           pop;
  mts_pkg::item_t push_item;
  mts_pkg::item_t pop_item;

  mts_front u_front (
    .in_chan   (in_chan),
    .fifo_full (fifo_full),
    .push      (push),
    .push_item (push_item)
  );

  // The queue lets new transactions land while the result register waits on the sink.
  mts_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_data  (push_item),
    .full     (fifo_full),
    .rd_en    (pop),
    .rd_valid (item_valid),
    .rd_data  (pop_item)
  );

  // The back end matches count, item, request and ack events against the peer key and local
  // identity, applies events to the transfer state combinationally, loads the result register.
  // Configuration writes land here as well, since identity writes are refused during a transfer.
  mts_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (pop_item),
    .pop        (pop),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_chan   (out_chan)
  );

endmodule
